[hdl/utf16be_to_utf8_transcoder_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the UTF-16BE to UTF-8 transcoder
// Shared property shapes used by the port checker.
// ----------------------------------------------------------------------------
`ifndef UTF16BE_TO_UTF8_TRANSCODER_CORE_ASSERT_SVH
`define UTF16BE_TO_UTF8_TRANSCODER_CORE_ASSERT_SVH

// a |=> b, checked outside reset
`define U16U8_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("u16u8 check failed");

// a |=> b, also checked while reset is applied
`define U16U8_ASSERT_NEXT_ALWAYS(lbl, clk, a, b) \
  lbl: assert property (@(posedge clk) (a) |=> (b)) \
    else $error("u16u8 reset check failed");

`endif

[hdl/u16u8_pkg.sv]
// ----------------------------------------------------------------------------
// u16u8_pkg
// Types, constants and encoding helpers for the UTF-16BE to UTF-8 transcoder.
// ----------------------------------------------------------------------------
package u16u8_pkg;

  localparam logic [15:0] HI_SURR_MIN = 16'hD800;
  localparam logic [15:0] HI_SURR_MAX = 16'hDBFF;
  localparam logic [15:0] LO_SURR_MIN = 16'hDC00;
  localparam logic [15:0] LO_SURR_MAX = 16'hDFFF;
  localparam logic [15:0] ONE_BYTE_LIM = 16'h0080;
  localparam logic [15:0] TWO_BYTE_LIM = 16'h0800;
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  localparam int unsigned JOB_BYTES = 6;
  localparam int unsigned Q_DEPTH = 2;

  // queue pointer and fill count widths follow the depth
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);
  localparam logic [Q_PTR_W-1:0] Q_LAST_PTR = Q_PTR_W'(Q_DEPTH - 1);
  localparam logic [Q_CNT_W-1:0] Q_FULL_CNT = Q_CNT_W'(Q_DEPTH);

  // One queued work entry: up to six output words, slot 0 goes out first.
  typedef struct packed {
    logic [JOB_BYTES-1:0][7:0] bytes;
    logic [2:0]                cnt;
  } job_t;

  // UTF-8 encoding of one 16-bit unit.
  typedef struct packed {
    logic [2:0][7:0] b;
    logic [1:0]      len;
  } enc_t;

  function automatic logic is_high_surr(input logic [15:0] u);
    return (u >= HI_SURR_MIN) && (u <= HI_SURR_MAX);
  endfunction

  function automatic logic is_low_surr(input logic [15:0] u);
    return (u >= LO_SURR_MIN) && (u <= LO_SURR_MAX);
  endfunction

  function automatic enc_t enc_unit(input logic [15:0] u);
    enc_t r;
    r = '0;
    if (u < ONE_BYTE_LIM) begin
      r.b[0] = {1'b0, u[6:0]};
      r.len  = 2'd1;
    end else if (u < TWO_BYTE_LIM) begin
      r.b[0] = {3'b110, u[10:6]};
      r.b[1] = {2'b10, u[5:0]};
      r.len  = 2'd2;
    end else begin
      r.b[0] = {4'b1110, u[15:12]};
      r.b[1] = {2'b10, u[11:6]};
      r.b[2] = {2'b10, u[5:0]};
      r.len  = 2'd3;
    end
    return r;
  endfunction

  // Four-byte form of a surrogate pair; slot 0 first.
  function automatic logic [3:0][7:0] enc_pair(input logic [15:0] hi, input logic [15:0] lo);
    logic [20:0]     cp;
    logic [3:0][7:0] r;
    cp   = SUPP_BASE + {1'b0, hi[9:0], lo[9:0]};
    r[0] = {5'b11110, cp[20:18]};
    r[1] = {2'b10, cp[17:12]};
    r[2] = {2'b10, cp[11:6]};
    r[3] = {2'b10, cp[5:0]};
    return r;
  endfunction

endpackage

[hdl/u16u8_front.sv]
// ----------------------------------------------------------------------------
// u16u8_front
// Accepts input words, pairs bytes into units and surrogates, builds jobs.
// ----------------------------------------------------------------------------
module u16u8_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_stop_at_null,
  input  logic             in_valid,
  input  logic [7:0]       in_byte_in,
  input  logic             in_end_of_string,
  input  logic             q_full,
  output logic             q_push,
  output u16u8_pkg::job_t  q_job
);

  logic        stop_r;
  logic [7:0]  held_r, held_nxt;
  logic        half_r, half_nxt;
  logic [15:0] pend_r, pend_nxt;
  logic        pend_vld_r, pend_vld_nxt;
  logic        stopped_r, stopped_nxt;

  logic            take;
  logic [15:0]     unit;
  logic            use_g1;
  logic [3:0][7:0] g2_b;
  logic [2:0]      g2_len;
  u16u8_pkg::enc_t enc_u;
  u16u8_pkg::enc_t enc_p;

  assign take  = in_valid && !q_full;
  assign unit  = {held_r, in_byte_in};
  assign enc_u = u16u8_pkg::enc_unit(unit);
  assign enc_p = u16u8_pkg::enc_unit(pend_r);

  always_comb begin
    held_nxt     = held_r;
    half_nxt     = half_r;
    pend_nxt     = pend_r;
    pend_vld_nxt = pend_vld_r;
    stopped_nxt  = stopped_r;
    use_g1       = 1'b0;
    g2_b         = '0;
    g2_len       = 3'd0;
    if (!stopped_r) begin
      if (!half_r) begin
        held_nxt = in_byte_in;
        half_nxt = 1'b1;
        use_g1   = in_end_of_string && pend_vld_r;
      end else begin
        half_nxt = 1'b0;
        held_nxt = 8'h00;
        if (stop_r && (unit == 16'h0000)) begin
          use_g1       = pend_vld_r;
          pend_vld_nxt = 1'b0;
          stopped_nxt  = 1'b1;
        end else if (pend_vld_r && u16u8_pkg::is_low_surr(unit)) begin
          g2_b         = u16u8_pkg::enc_pair(pend_r, unit);
          g2_len       = 3'd4;
          pend_vld_nxt = 1'b0;
        end else begin
          use_g1       = pend_vld_r;
          pend_vld_nxt = 1'b0;
          if (u16u8_pkg::is_high_surr(unit) && !in_end_of_string) begin
            pend_nxt     = unit;
            pend_vld_nxt = 1'b1;
          end else begin
            // other units, and a high surrogate at end of string, are encoded right away
            g2_b[2:0] = enc_u.b;
            g2_len    = {1'b0, enc_u.len};
          end
        end
      end
    end
    if (in_end_of_string) begin
      held_nxt     = 8'h00;
      half_nxt     = 1'b0;
      pend_vld_nxt = 1'b0;
      stopped_nxt  = 1'b0;
    end
  end

  always_comb begin
    q_job = '0;
    if (use_g1) begin
      q_job.bytes[2:0] = enc_p.b;
      q_job.bytes[5:3] = g2_b[2:0];
      q_job.cnt        = 3'd3 + g2_len;
    end else begin
      q_job.bytes[3:0] = g2_b;
      q_job.cnt        = g2_len;
    end
  end

  assign q_push = take && (q_job.cnt != 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_r     <= 1'b0;
      half_r     <= 1'b0;
      pend_vld_r <= 1'b0;
      stopped_r  <= 1'b0;
      held_r     <= 8'h00;
    end else begin
      if (cfg_we) begin
        stop_r <= cfg_stop_at_null;
      end
      if (take) begin
        half_r     <= half_nxt;
        pend_vld_r <= pend_vld_nxt;
        stopped_r  <= stopped_nxt;
        held_r     <= held_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pend_r <= pend_nxt;
    end
  end

endmodule

[hdl/u16u8_queue.sv]
// ----------------------------------------------------------------------------
// u16u8_queue
// Two-entry job queue between front and back.
// ----------------------------------------------------------------------------
module u16u8_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  u16u8_pkg::job_t  push_job,
  input  logic             pop,
  output logic             full,
  output logic             empty,
  output u16u8_pkg::job_t  head
);

  u16u8_pkg::job_t mem_r [u16u8_pkg::Q_DEPTH];
  logic [u16u8_pkg::Q_PTR_W-1:0] wr_ptr_r;
  logic [u16u8_pkg::Q_PTR_W-1:0] rd_ptr_r;
  logic [u16u8_pkg::Q_CNT_W-1:0] cnt_r;

  assign full  = (cnt_r == u16u8_pkg::Q_FULL_CNT);
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == u16u8_pkg::Q_LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == u16u8_pkg::Q_LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

[hdl/u16u8_back.sv]
// ----------------------------------------------------------------------------
// u16u8_back
// Streams queued jobs out one word per unstalled cycle via an output register.
// ----------------------------------------------------------------------------
module u16u8_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  u16u8_pkg::job_t  q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_out_byte,
  output logic             out_last_of_run
);

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic [2:0] idx_r;
  logic       slot_free;
  logic       is_last;
  logic       load;

  assign slot_free = !out_valid_r || !out_stall;
  assign load      = slot_free && !q_empty;
  assign is_last   = (idx_r == (q_head.cnt - 3'd1));
  assign q_pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 3'd0;
    end else if (slot_free) begin
      out_valid_r <= !q_empty;
      if (load) begin
        idx_r <= is_last ? 3'd0 : idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= q_head.bytes[idx_r];
      out_last_r <= is_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_out_byte    = out_byte_r;
  assign out_last_of_run = out_last_r;

endmodule

[hdl/utf16be_to_utf8_transcoder_core.sv]
// ----------------------------------------------------------------------------
// utf16be_to_utf8_transcoder_core
// UTF-16 big-endian byte stream in, UTF-8 byte stream out.
// ----------------------------------------------------------------------------
// Each input word is one byte of a big-endian UTF-16 string; end_of_string
// marks its last byte and flushes and clears all stream state. Each output
// word is one UTF-8 byte, with last_of_run set on the final byte caused by a
// given input word (input words that cause nothing produce no output). The
// front accepts an input word every cycle while the two-entry job queue has
// room, decodes units and surrogate pairs and writes one job of up to six
// bytes; the back drains jobs at one output word per cycle while out_stall is
// low. Throughput is therefore set by the output port, which carries every
// byte that an input word produces. The first output word of an input word
// reaches the output port through the queue write, then the output register.
// Setting stop_at_null makes a 0x0000 unit end conversion until the next
// end_of_string; write it only while the block is idle.
module utf16be_to_utf8_transcoder_core (
  input  logic       clk,
  input  logic       rst_n,
  // configuration
  input  logic       cfg_we,
  input  logic       cfg_stop_at_null,
  // input words
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte_in,
  input  logic       in_end_of_string,
  // output words
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_out_byte,
  output logic       out_last_of_run
);

  logic            q_push;
  logic            q_pop;
  logic            q_full;
  logic            q_empty;
  u16u8_pkg::job_t q_push_job;
  u16u8_pkg::job_t q_head;

  // stall comes straight from the queue fill state
  assign in_stall = q_full;

  u16u8_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_stop_at_null (cfg_stop_at_null),
    .in_valid         (in_valid),
    .in_byte_in       (in_byte_in),
    .in_end_of_string (in_end_of_string),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_job            (q_push_job)
  );

  u16u8_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_push_job),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (q_head)
  );

  u16u8_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_out_byte    (out_out_byte),
    .out_last_of_run (out_last_of_run)
  );

endmodule

[hdl/u16u8_checker.sv]
// ----------------------------------------------------------------------------
// u16u8_checker
// Port-level checks for the transcoder, bound onto the top level.
// ----------------------------------------------------------------------------
`include "utf16be_to_utf8_transcoder_core_assert.svh"

module u16u8_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_stall,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       out_last_of_run
);

  // held output keeps its valid
  `U16U8_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

  // multi-byte sequence goes out without gaps
  `U16U8_ASSERT_NEXT(a_run_gapless, clk, rst_n, out_valid && !out_stall && !out_last_of_run, out_valid)

  // reset empties the output register
  `U16U8_ASSERT_NEXT_ALWAYS(a_rst_out, clk, !rst_n, !out_valid)

  // reset empties the queue, so the input side opens
  `U16U8_ASSERT_NEXT_ALWAYS(a_rst_in, clk, !rst_n, !in_stall)

endmodule

bind utf16be_to_utf8_transcoder_core u16u8_checker u_chk (.*);

[test/utf8_output_checker.sv]
// ----------------------------------------------------------------------------
// utf8_output_checker
// Watches the transcoder's ports, predicts the UTF-8 bytes each accepted
// input word must produce and compares them in order with what comes out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_output_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_stop_at_null,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_byte_in,
  input  logic       in_end_of_string,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_out_byte,
  input  logic       out_last_of_run,
  output int         n_fail,
  output int         n_pending,
  output int         n_checked
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } utf8_word_t;

  utf8_word_t  utf8_expected_q[$];
  logic [7:0]  run_bytes_q[$];

  // Mirror of the transcoder's stream state
  logic        stop_mode    = 1'b0;
  logic [7:0]  lead_byte    = '0;
  logic        lead_ok      = 1'b0;
  logic [15:0] held_surr    = '0;
  logic        held_surr_ok = 1'b0;
  logic        halted       = 1'b0;

  int fails   = 0;
  int checked = 0;

  function automatic void add_run_byte(input logic [7:0] b);
    run_bytes_q = {run_bytes_q, b};
  endfunction

  function automatic void encode_unit(input logic [15:0] u);
    logic [15:0] t;
    if (u < u16u8_pkg::ONE_BYTE_LIM) begin
      add_run_byte(u[7:0]);
    end else if (u < u16u8_pkg::TWO_BYTE_LIM) begin
      t = 16'h00C0 | (u >> 6);
      add_run_byte(t[7:0]);
      t = 16'h0080 | (u & 16'h003F);
      add_run_byte(t[7:0]);
    end else begin
      t = 16'h00E0 | (u >> 12);
      add_run_byte(t[7:0]);
      t = 16'h0080 | ((u >> 6) & 16'h003F);
      add_run_byte(t[7:0]);
      t = 16'h0080 | (u & 16'h003F);
      add_run_byte(t[7:0]);
    end
  endfunction

  function automatic void flush_held_surr();
    if (held_surr_ok) begin
      encode_unit(held_surr);
      held_surr_ok = 1'b0;
      held_surr    = '0;
    end
  endfunction

  function automatic void clear_stream();
    lead_byte    = '0;
    lead_ok      = 1'b0;
    held_surr    = '0;
    held_surr_ok = 1'b0;
    halted       = 1'b0;
  endfunction

  function automatic void decode_unit(input logic [15:0] u);
    logic [20:0] hs;
    logic [20:0] ls;
    logic [20:0] cp;
    logic [20:0] t;
    if (stop_mode && u == 16'h0000) begin
      flush_held_surr();
      halted = 1'b1;
      return;
    end
    if (held_surr_ok) begin
      if (u >= u16u8_pkg::LO_SURR_MIN && u <= u16u8_pkg::LO_SURR_MAX) begin
        hs = {5'b0, held_surr};
        ls = {5'b0, u};
        cp = 21'h10000 + (((hs - 21'h0D800) << 10) | (ls - 21'h0DC00));
        t = 21'h0000F0 | ((cp >> 18) & 21'h7);
        add_run_byte(t[7:0]);
        t = 21'h000080 | ((cp >> 12) & 21'h3F);
        add_run_byte(t[7:0]);
        t = 21'h000080 | ((cp >> 6) & 21'h3F);
        add_run_byte(t[7:0]);
        t = 21'h000080 | (cp & 21'h3F);
        add_run_byte(t[7:0]);
        held_surr_ok = 1'b0;
        held_surr    = '0;
        return;
      end
      flush_held_surr();
    end
    if (u >= u16u8_pkg::HI_SURR_MIN && u <= u16u8_pkg::HI_SURR_MAX) begin
      held_surr    = u;
      held_surr_ok = 1'b1;
      return;
    end
    encode_unit(u);
  endfunction

  function automatic void predict_word(input logic [7:0] b, input logic eos);
    utf8_word_t w;
    run_bytes_q.delete();
    if (!halted) begin
      if (!lead_ok) begin
        lead_byte = b;
        lead_ok   = 1'b1;
      end else begin
        lead_ok = 1'b0;
        decode_unit({lead_byte, b});
        lead_byte = '0;
      end
      if (eos) flush_held_surr();
    end
    if (eos) clear_stream();
    for (int k = 0; k < run_bytes_q.size(); k++) begin
      w.data = run_bytes_q[k];
      w.last = (k == run_bytes_q.size() - 1);
      utf8_expected_q = {utf8_expected_q, w};
    end
  endfunction

  always @(posedge clk) begin : monitor
    utf8_word_t exp_w;
    if (!rst_n) begin
      stop_mode = 1'b0;
      clear_stream();
      utf8_expected_q.delete();
    end else begin
      // input first: a register write counts from the next unit on
      if (in_valid && !in_stall) predict_word(in_byte_in, in_end_of_string);
      if (cfg_we) stop_mode = cfg_stop_at_null;
      if (out_valid && !out_stall) begin
        if (utf8_expected_q.size() == 0) begin
          $error("unexpected output word: out_byte %02h last_of_run %0b",
                 out_out_byte, out_last_of_run);
          fails++;
        end else begin
          exp_w = utf8_expected_q.pop_front();
          checked++;
          if (out_out_byte !== exp_w.data) begin
            $error("out_byte: expected %02h, got %02h", exp_w.data, out_out_byte);
            fails++;
          end
          if (out_last_of_run !== exp_w.last) begin
            $error("last_of_run: expected %0b, got %0b", exp_w.last, out_last_of_run);
            fails++;
          end
        end
      end
    end
    n_fail    <= fails;
    n_pending <= utf8_expected_q.size();
    n_checked <= checked;
  end

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// UTF-16BE to UTF-8 transcoder: directed boundary strings, then random
// strings under both null-stop settings with random gaps and output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int CLK_HALF        = 4;
  localparam int RESET_CYCLES    = 10;
  localparam int TIMEOUT_CYCLES  = 600000;
  localparam int HOLD_CYCLES     = 200;
  localparam int DRAIN_CYCLES    = 8;
  localparam int WORDS_PER_PHASE = 135;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_stop_at_null;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte_in;
  logic       in_end_of_string;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_out_byte;
  logic       out_last_of_run;

  int n_fail;
  int n_pending;
  int n_checked;
  int words_sent   = 0;
  int strings_sent = 0;
  int cycle_count  = 0;
  int holds_done   = 0;
  bit hold_req     = 1'b0;

  // bytes of the string about to be sent
  logic [7:0] utf16_bytes_q[$];

  always #(CLK_HALF) clk = ~clk;

  utf16be_to_utf8_transcoder_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_stop_at_null (cfg_stop_at_null),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte_in       (in_byte_in),
    .in_end_of_string (in_end_of_string),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_out_byte     (out_out_byte),
    .out_last_of_run  (out_last_of_run)
  );

  utf8_output_checker chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_stop_at_null (cfg_stop_at_null),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte_in       (in_byte_in),
    .in_end_of_string (in_end_of_string),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_out_byte     (out_out_byte),
    .out_last_of_run  (out_last_of_run),
    .n_fail           (n_fail),
    .n_pending        (n_pending),
    .n_checked        (n_checked)
  );

  // Watchdog: a hung handshake ends the run here
  initial begin : watchdog
    while (cycle_count < TIMEOUT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // Gap after a word: mostly none, often a few cycles, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one word and hold it until the block takes it. Valid stays high
  // into the next word when no gap follows.
  task automatic send_word(input logic [7:0] b, input logic eos, input bit gapless);
    int gap;
    in_byte_in       <= b;
    in_end_of_string <= eos;
    in_valid         <= 1'b1;
    do @(posedge clk); while (in_stall);
    words_sent++;
    gap = gapless ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Send the queued bytes; end_of_string goes on the last one if asked.
  // About one string in four goes out back to back.
  task automatic send_string(input logic close_string);
    bit gapless;
    gapless = ($urandom_range(0, 3) == 0);
    for (int k = 0; k < utf16_bytes_q.size(); k++) begin
      send_word(utf16_bytes_q[k], close_string && (k == utf16_bytes_q.size() - 1), gapless);
    end
    if (close_string) strings_sent++;
  endtask

  function automatic void add_string_byte(input logic [7:0] b);
    utf16_bytes_q = {utf16_bytes_q, b};
  endfunction

  function automatic void queue_unit(input logic [15:0] u);
    add_string_byte(u[15:8]);
    add_string_byte(u[7:0]);
  endfunction

  // Mostly well-formed text with every unit class; some lone surrogates,
  // nulls, odd trailing bytes and plain byte noise.
  task automatic build_random_string();
    int n_units;
    int r;
    utf16_bytes_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 15)) add_string_byte(8'($urandom_range(0, 255)));
    end else begin
      n_units = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 8);
      repeat (n_units) begin
        r = $urandom_range(0, 99);
        if (r < 20) begin
          queue_unit(16'($urandom_range(1, 16'h007F)));
        end else if (r < 35) begin
          queue_unit(16'($urandom_range(16'h0080, 16'h07FF)));
        end else if (r < 50) begin
          if ($urandom_range(0, 1) == 0) queue_unit(16'($urandom_range(16'h0800, 16'hD7FF)));
          else queue_unit(16'($urandom_range(16'hE000, 16'hFFFF)));
        end else if (r < 70) begin
          // proper surrogate pair
          queue_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
          queue_unit(16'($urandom_range(16'hDC00, 16'hDFFF)));
        end else if (r < 77) begin
          queue_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
        end else if (r < 84) begin
          queue_unit(16'($urandom_range(16'hDC00, 16'hDFFF)));
        end else if (r < 89) begin
          queue_unit(16'h0000);
        end else begin
          queue_unit(16'($urandom_range(0, 16'hFFFF)));
        end
      end
      // odd trailing byte, dropped at end_of_string
      if ($urandom_range(0, 5) == 0) add_string_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Wait until every predicted byte has come out, then allow for words
  // that produce nothing but may still be in flight.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (n_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_stop_mode(input logic mode);
    wait_drained();
    cfg_stop_at_null <= mode;
    cfg_we           <= 1'b1;
    @(posedge clk);
    cfg_we           <= 1'b0;
  endtask

  // Output stall: stall-free stretches, short random stalls, the odd long
  // one, and one long hold-off on request so the input side backs up.
  initial begin : output_stall_driver
    int run;
    int r;
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        holds_done++;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 40) begin
          out_stall <= 1'b0;
          run = $urandom_range(5, 60);
        end else if (r < 90) begin
          out_stall <= 1'($urandom_range(0, 1));
          run = $urandom_range(1, 3);
        end else begin
          out_stall <= 1'b1;
          run = $urandom_range(10, 40);
        end
        repeat (run) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int phase_start;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_stop_at_null = 1'b0;
    in_valid         = 1'b0;
    in_byte_in       = '0;
    in_end_of_string = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_stop_mode(1'b0);

    // length boundaries: 0x0080, 0x07FF, 0x0800 and 0xFFFF
    utf16_bytes_q = '{8'h00, 8'h80, 8'h07, 8'hFF, 8'h08, 8'h00, 8'hFF, 8'hFF};
    send_string(1'b0);
    // lowest and highest surrogate pairs
    utf16_bytes_q = '{8'hD8, 8'h00, 8'hDC, 8'h00, 8'hDB, 8'hFF, 8'hDF, 8'hFF};
    send_string(1'b0);
    // high surrogate broken by 0x007F, lone low, null as a plain byte, then a
    // high surrogate flushed by end_of_string on an odd trailing byte
    utf16_bytes_q = '{8'hD8, 8'h3D, 8'h00, 8'h7F, 8'hDC, 8'h00, 8'h00, 8'h00,
                      8'hD8, 8'h00, 8'h12};
    send_string(1'b1);
    // high surrogate completed on the end_of_string byte
    utf16_bytes_q = '{8'hD8, 8'h01};
    send_string(1'b1);

    // null stop: the held surrogate is flushed, then everything is ignored
    write_stop_mode(1'b1);
    utf16_bytes_q = '{8'hD8, 8'h00, 8'h00, 8'h00, 8'h41};
    send_string(1'b0);
    // clearing the mode mid-string does not resume; end_of_string does
    write_stop_mode(1'b0);
    utf16_bytes_q = '{8'h42, 8'h00};
    send_string(1'b1);

    // Random phases. The first one also holds off the output for a long
    // stretch while words keep coming.
    for (int p = 0; p < 3; p++) begin
      write_stop_mode(p == 1);
      if (p == 0) hold_req = 1'b1;
      phase_start = words_sent;
      while (words_sent - phase_start < WORDS_PER_PHASE) begin
        build_random_string();
        // now and then strings run together without end_of_string
        send_string($urandom_range(0, 6) != 0);
      end
    end

    wait_drained();
    $display("tb: %0d input words in %0d strings, %0d UTF-8 bytes checked",
             words_sent, strings_sent, n_checked);
    $display("tb: null stop off and on, %0d long output hold-off(s)", holds_done);
    if (n_fail == 0 && n_pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/u16u8_pkg.sv
hdl/u16u8_front.sv
hdl/u16u8_queue.sv
hdl/u16u8_back.sv
hdl/utf16be_to_utf8_transcoder_core.sv
hdl/u16u8_checker.sv
test/utf8_output_checker.sv
test/tb.sv
